@@ src/svf_pkg.sv @@
// Package with widths, codes and control types shared by the state variable filter.
`default_nettype none

package svf_pkg;

    localparam int FRACTION_BITS = 14;
    localparam int SAMPLE_W      = 16;
    localparam int DATA_W        = 32;
    localparam int TUNING_W      = 15;
    localparam int DAMPING_W     = 16;
    localparam int COEF_W        = 16;
    localparam int MODE_W        = 2;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 16;
    localparam int PROD_W        = FRACTION_BITS + DATA_W;

    localparam logic [DAMPING_W-1:0] DAMPING_RESET = DAMPING_W'(23170);

    localparam logic [CFG_INDEX_W-1:0] REG_TUNING  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DAMPING = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MODE    = 2'd2;

    localparam logic [MODE_W-1:0] MODE_LOWPASS   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_HIGHPASS  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BANDPASS  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_BANDREJECT = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_BF,
        ST_MUL_BD,
        ST_ACC_HP,
        ST_MUL_HF,
        ST_ACC_BP,
        ST_MUL_BPD,
        ST_FINISH
    } svf_state_t;

    typedef enum logic {
        OPA_BAND,
        OPA_HP
    } svf_opa_t;

    typedef enum logic {
        COEF_TUNING,
        COEF_DAMPING
    } svf_coef_t;

    typedef struct packed {
        logic      load_sample;
        logic      mul_en;
        svf_opa_t  opa_sel;
        svf_coef_t coef_sel;
        logic      load_lp;
        logic      load_hp;
        logic      update_state;
        logic      load_result;
    } svf_cmd_t;

endpackage

`default_nettype wire

@@ src/svf_datapath.sv @@
// Datapath of the state variable filter: registers, shared multiplier and result registers.
`default_nettype none

module svf_datapath
    import svf_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire svf_cmd_t                  cmd,
    input  wire logic                      cfg_we,
    input  wire logic [CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [CFG_DATA_W-1:0]     cfg_data,
    input  wire logic signed [SAMPLE_W-1:0] sample_in,
    output logic signed [DATA_W-1:0]       selected_out,
    output logic signed [DATA_W-1:0]       lowpass_out,
    output logic signed [DATA_W-1:0]       highpass_out,
    output logic signed [DATA_W-1:0]       bandpass_out,
    output logic signed [DATA_W-1:0]       bandreject_out
);

    logic [TUNING_W-1:0]      tuning_reg;
    logic [DAMPING_W-1:0]     damping_reg;
    logic [MODE_W-1:0]        mode_reg;

    logic signed [DATA_W-1:0] band_reg;
    logic signed [DATA_W-1:0] low_reg;
    logic signed [DATA_W-1:0] x_reg;
    logic signed [DATA_W-1:0] lp_reg;
    logic signed [DATA_W-1:0] hp_reg;
    logic signed [PROD_W-1:0] prod_reg;

    logic signed [DATA_W-1:0] sel_reg;
    logic signed [DATA_W-1:0] lowpass_reg;
    logic signed [DATA_W-1:0] highpass_reg;
    logic signed [DATA_W-1:0] bandpass_reg;
    logic signed [DATA_W-1:0] bandreject_reg;

    logic signed [DATA_W-1:0] opa;
    logic        [COEF_W-1:0] coef;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [DATA_W-1:0] scaled;
    logic signed [DATA_W-1:0] bandreject_next;
    logic signed [DATA_W-1:0] sel_next;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tuning_reg  <= '0;
            damping_reg <= DAMPING_RESET;
            mode_reg    <= MODE_LOWPASS;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TUNING:  tuning_reg  <= cfg_data[TUNING_W-1:0];
                REG_DAMPING: damping_reg <= cfg_data[DAMPING_W-1:0];
                REG_MODE:    mode_reg    <= cfg_data[MODE_W-1:0];
                default:     ;
            endcase
        end
    end

    // Shared multiplier: signed operand times unsigned coefficient.
    always_comb
    begin
        opa  = (cmd.opa_sel == OPA_HP) ? hp_reg : band_reg;
        coef = (cmd.coef_sel == COEF_DAMPING) ? damping_reg : COEF_W'(tuning_reg);
        prod_next = PROD_W'(opa) * PROD_W'($signed({1'b0, coef}));
    end

    // The arithmetic shift by the fraction bits, truncated to the data width.
    assign scaled = prod_reg[FRACTION_BITS +: DATA_W];

    assign bandreject_next = lp_reg + hp_reg;

    always_comb
    begin
        case (mode_reg)
            MODE_LOWPASS:   sel_next = lp_reg;
            MODE_HIGHPASS:  sel_next = hp_reg;
            MODE_BANDPASS:  sel_next = scaled;
            MODE_BANDREJECT: sel_next = bandreject_next;
            default:        sel_next = lp_reg;
        endcase
    end

    // Filter state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            band_reg <= '0;
            low_reg  <= '0;
        end
        else if (cmd.update_state)
        begin
            band_reg <= scaled + band_reg;
            low_reg  <= lp_reg;
        end
    end

    // Working and result registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load_sample)
        begin
            x_reg <= DATA_W'(sample_in);
        end
        if (cmd.mul_en)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.load_lp)
        begin
            lp_reg <= scaled + low_reg;
        end
        if (cmd.load_hp)
        begin
            hp_reg <= x_reg - scaled - lp_reg;
        end
        if (cmd.load_result)
        begin
            sel_reg        <= sel_next;
            lowpass_reg    <= lp_reg;
            highpass_reg   <= hp_reg;
            bandpass_reg   <= scaled;
            bandreject_reg <= bandreject_next;
        end
    end

    assign selected_out   = sel_reg;
    assign lowpass_out    = lowpass_reg;
    assign highpass_out   = highpass_reg;
    assign bandpass_out   = bandpass_reg;
    assign bandreject_out = bandreject_reg;

endmodule

`default_nettype wire

@@ src/svf_controller.sv @@
// Controller state machine that sequences one sample through the filter datapath.
`default_nettype none

module svf_controller
    import svf_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic sample_valid,
    output logic      sample_ready,
    output logic      result_valid,
    input  wire logic result_ready,
    output svf_cmd_t  cmd
);

    svf_state_t state_reg;
    svf_state_t state_next;
    logic       result_valid_reg;
    logic       result_valid_next;
    logic       slot_free;

    assign slot_free = !result_valid_reg || result_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:    if (sample_valid) state_next = ST_MUL_BF;
            ST_MUL_BF:  state_next = ST_MUL_BD;
            ST_MUL_BD:  state_next = ST_ACC_HP;
            ST_ACC_HP:  state_next = ST_MUL_HF;
            ST_MUL_HF:  state_next = ST_ACC_BP;
            ST_ACC_BP:  state_next = ST_MUL_BPD;
            ST_MUL_BPD: state_next = ST_FINISH;
            ST_FINISH:  if (slot_free) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.opa_sel  = OPA_BAND;
        cmd.coef_sel = COEF_TUNING;
        sample_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                sample_ready    = 1'b1;
                cmd.load_sample = sample_valid;
            end
            ST_MUL_BF:
            begin
                cmd.mul_en = 1'b1;
            end
            ST_MUL_BD:
            begin
                cmd.mul_en   = 1'b1;
                cmd.coef_sel = COEF_DAMPING;
                cmd.load_lp  = 1'b1;
            end
            ST_ACC_HP:
            begin
                cmd.load_hp = 1'b1;
            end
            ST_MUL_HF:
            begin
                cmd.mul_en  = 1'b1;
                cmd.opa_sel = OPA_HP;
            end
            ST_ACC_BP:
            begin
                cmd.update_state = 1'b1;
            end
            ST_MUL_BPD:
            begin
                cmd.mul_en   = 1'b1;
                cmd.coef_sel = COEF_DAMPING;
            end
            ST_FINISH:
            begin
                cmd.load_result = slot_free;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        if (cmd.load_result)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
        else
        begin
            result_valid_next = result_valid_reg;
        end
    end

    assign result_valid = result_valid_reg;

endmodule

`default_nettype wire

@@ src/state_variable_filter.sv @@
// Top level of the fixed-point Chamberlin state variable filter.
//
//  Channel   Signals                                    Direction
//  cfg       cfg_valid, cfg_ready, cfg_index, cfg_data  in
//  sample    sample_valid, sample_ready, sample_in      in
//  result    result_valid, result_ready, *_out          out
//
// From the acceptance of a sample to the next acceptance, four products go
// through the one shared multiplier, each followed by an accumulate step.
// The result registers hold a finished transaction while the next sample is worked on;
// the final step waits only if the previous result has not been taken.
// Reset clears both integrators and loads the register defaults; no clearing pass.
// Configuration writes are taken in any cycle.
`default_nettype none

module state_variable_filter
    import svf_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [CFG_DATA_W-1:0]      cfg_data,
    input  wire logic                       sample_valid,
    output logic                            sample_ready,
    input  wire logic signed [SAMPLE_W-1:0] sample_in,
    output logic                            result_valid,
    input  wire logic                       result_ready,
    output logic signed [DATA_W-1:0]        selected_out,
    output logic signed [DATA_W-1:0]        lowpass_out,
    output logic signed [DATA_W-1:0]        highpass_out,
    output logic signed [DATA_W-1:0]        bandpass_out,
    output logic signed [DATA_W-1:0]        bandreject_out
);

    svf_cmd_t cmd;

    assign cfg_ready = 1'b1;

    svf_controller u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .cmd          (cmd)
    );

    svf_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .cfg_we         (cfg_valid && cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .sample_in      (sample_in),
        .selected_out   (selected_out),
        .lowpass_out    (lowpass_out),
        .highpass_out   (highpass_out),
        .bandpass_out   (bandpass_out),
        .bandreject_out (bandreject_out)
    );

    // A new result is never written over one that has not been taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_result |-> (!result_valid || result_ready))
        else $error("result register overwritten before its transaction");

    // Loading a result presents it on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_result |=> result_valid)
        else $error("loaded result not presented");

    // Once a sample is taken, the block is busy with it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (sample_valid && sample_ready) |=> !sample_ready)
        else $error("sample taken while previous sample in progress");

    // The sample register loads only on an accepted transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_sample |-> (sample_valid && sample_ready))
        else $error("sample loaded without a transaction");

endmodule

`default_nettype wire
